@@ design/lpht_pkg.sv @@
// Shared constants, codes and types of the linear-probe hash table.
// No dependencies; the hash unit and the top level refer to it by scoped names.
package lpht_pkg;

  localparam int unsigned TABLE_SLOTS = 8;
  localparam int unsigned SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned MARK_W      = 2;
  localparam bit          SLOTS_POW2  = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

  // operation codes
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_SEARCH = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;

  // slot marks
  localparam logic [MARK_W-1:0] MARK_EMPTY   = 2'd0;
  localparam logic [MARK_W-1:0] MARK_USED    = 2'd1;
  localparam logic [MARK_W-1:0] MARK_DELETED = 2'd2;

  // result status codes
  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_FOUND     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_DELETED   = 3'd4;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              done;
    logic [SLOT_W-1:0] home;
  } hash_res_t;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    return (s == LAST_SLOT) ? '0 : s + SLOT_W'(1);
  endfunction

  // low three bits of a slot number, zero-extended for small tables
  function automatic logic [2:0] slot_field(input logic [SLOT_W-1:0] s);
    logic [SLOT_W+2:0] wide;
    wide = {3'b000, s};
    return wide[2:0];
  endfunction

endpackage

@@ design/lpht_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module lpht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/lpht_hash.sv @@
// Home-slot unit: key modulo the table size.
// Depends on lpht_pkg.
module lpht_hash (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [lpht_pkg::KEY_W-1:0]  key,
  output lpht_pkg::hash_res_t         res
);

  if (lpht_pkg::SLOTS_POW2) begin : g_mask
    logic                            done_r;
    logic [lpht_pkg::SLOT_W-1:0]     home_r;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        done_r <= 1'b0;
      end else begin
        done_r <= start;
      end
    end

    always_ff @(posedge clk) begin
      if (start) begin
        home_r <= key[lpht_pkg::SLOT_W-1:0];
      end
    end

    assign res.done = done_r;
    assign res.home = home_r;
  end else begin : g_iter
    // four key bits per step, remainder kept below the table size
    localparam int unsigned RW = lpht_pkg::SLOT_W + 4;
    localparam logic [RW-1:0] MODV = RW'(lpht_pkg::TABLE_SLOTS);

    logic                        busy_r;
    logic                        done_r;
    logic [2:0]                  step_r;
    logic [lpht_pkg::KEY_W-1:0]  keysh_r;
    logic [lpht_pkg::SLOT_W-1:0] rem_r;
    logic [RW-1:0]               red;

    always_comb begin
      red = {rem_r, keysh_r[lpht_pkg::KEY_W-1 -: 4]};
      for (int k = 3; k >= 0; k--) begin
        if (red >= (MODV << k)) begin
          red = red - (MODV << k);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        busy_r <= 1'b0;
        done_r <= 1'b0;
        step_r <= '0;
      end else begin
        done_r <= busy_r && (step_r == 3'd7);
        if (start) begin
          busy_r <= 1'b1;
          step_r <= '0;
        end else if (busy_r) begin
          step_r <= step_r + 3'd1;
          if (step_r == 3'd7) begin
            busy_r <= 1'b0;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (start) begin
        keysh_r <= key;
        rem_r   <= '0;
      end else if (busy_r) begin
        keysh_r <= {keysh_r[lpht_pkg::KEY_W-5:0], 4'b0000};
        rem_r   <= red[lpht_pkg::SLOT_W-1:0];
      end
    end

    assign res.done = done_r;
    assign res.home = rem_r;
  end

endmodule

@@ design/linear_probe_hash_table_top.sv @@
// Top level of the linear-probe hash table: sequencer, key and mark memories.
// Depends on lpht_pkg, lpht_ram and lpht_hash.
//
//   channel | ports                          | moves
//   --------+--------------------------------+-----------------------------
//   in      | in_valid in_stall in_func in_key  | one request: op and key
//   out     | out_valid out_stall out_status out_slot | one result per request
//
// Sequence: a request is taken in the idle state; the hash unit finds the home
// slot, then the probe walks the slot memories one slot per cycle until it stops,
// and the done state loads the result into the output register.
// Reset: a clearing pass writes every mark empty, with in_stall high. A
// stalled result holds in the output register; the next request is taken
// meanwhile and waits in the done state only if it finishes before the
// earlier result is gone.
module linear_probe_hash_table_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_func,
  input  logic [lpht_pkg::KEY_W-1:0] in_key,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [2:0]                 out_status,
  output logic [2:0]                 out_slot
);

  lpht_pkg::state_t state_r, state_nxt;

  logic [1:0]                    func_r;
  logic [lpht_pkg::KEY_W-1:0]    key_r;
  logic [lpht_pkg::SLOT_W-1:0]   cur_r;
  logic [lpht_pkg::SLOT_W-1:0]   cnt_r;
  logic [lpht_pkg::SLOT_W-1:0]   clr_r;
  logic [2:0]                    res_status_r;
  logic [2:0]                    res_slot_r;
  logic                          out_valid_r;
  logic [2:0]                    out_status_r;
  logic [2:0]                    out_slot_r;

  logic                          in_acc;
  logic                          out_free;
  lpht_pkg::hash_res_t           hash_res;

  // memory ports
  logic                          rd_en;
  logic [lpht_pkg::SLOT_W-1:0]   rd_addr;
  logic [lpht_pkg::KEY_W-1:0]    rd_key;
  logic [lpht_pkg::MARK_W-1:0]   rd_mark;
  logic                          key_we;
  logic                          mark_we;
  logic [lpht_pkg::SLOT_W-1:0]   wr_addr;
  logic [lpht_pkg::MARK_W-1:0]   mark_wdata;

  // probe decision
  logic                          stop;
  logic                          hit_write;
  logic                          hit_key_write;
  logic [lpht_pkg::MARK_W-1:0]   hit_mark;
  logic [2:0]                    stop_status;
  logic [2:0]                    stop_slot;

  assign in_stall = (state_r != lpht_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  lpht_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc),
    .key   (in_key),
    .res   (hash_res)
  );

  lpht_ram #(
    .WIDTH (lpht_pkg::KEY_W),
    .DEPTH (lpht_pkg::TABLE_SLOTS)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (wr_addr),
    .wdata (key_r),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_key)
  );

  lpht_ram #(
    .WIDTH (lpht_pkg::MARK_W),
    .DEPTH (lpht_pkg::TABLE_SLOTS)
  ) u_mark_ram (
    .clk   (clk),
    .we    (mark_we),
    .waddr (wr_addr),
    .wdata (mark_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_mark)
  );

  // Judge the slot whose mark and key arrived this cycle. A mark of three
  // counts as empty: it is neither used nor deleted.
  always_comb begin
    logic used, deleted, key_hit, last;
    used          = (rd_mark == lpht_pkg::MARK_USED);
    deleted       = (rd_mark == lpht_pkg::MARK_DELETED);
    key_hit       = used && (rd_key == key_r);
    last          = (cnt_r == lpht_pkg::LAST_SLOT);
    stop          = 1'b0;
    hit_write     = 1'b0;
    hit_key_write = 1'b0;
    hit_mark      = lpht_pkg::MARK_USED;
    stop_status   = lpht_pkg::ST_NOT_FOUND;
    stop_slot     = 3'b000;
    unique case (func_r)
      lpht_pkg::FUNC_INSERT: begin
        if (!used) begin
          // take the first free or deleted slot
          stop          = 1'b1;
          hit_write     = 1'b1;
          hit_key_write = 1'b1;
          hit_mark      = lpht_pkg::MARK_USED;
          stop_status   = lpht_pkg::ST_INSERTED;
          stop_slot     = lpht_pkg::slot_field(cur_r);
        end else if (last) begin
          stop        = 1'b1;
          stop_status = lpht_pkg::ST_FULL;
        end
      end
      lpht_pkg::FUNC_SEARCH, lpht_pkg::FUNC_REMOVE: begin
        if (key_hit) begin
          stop      = 1'b1;
          stop_slot = lpht_pkg::slot_field(cur_r);
          if (func_r == lpht_pkg::FUNC_REMOVE) begin
            // leave a tombstone so later chains stay intact
            hit_write   = 1'b1;
            hit_mark    = lpht_pkg::MARK_DELETED;
            stop_status = lpht_pkg::ST_DELETED;
          end else begin
            stop_status = lpht_pkg::ST_FOUND;
          end
        end else if ((!used && !deleted) || last) begin
          // an empty slot ends the chain; used and deleted slots are passed
          stop = 1'b1;
        end
      end
      default: begin
        // unused code: answer not found, touch nothing
        stop = 1'b1;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lpht_pkg::ST_CLEAR: if (clr_r == lpht_pkg::LAST_SLOT) state_nxt = lpht_pkg::ST_IDLE;
      lpht_pkg::ST_IDLE:  if (in_acc) state_nxt = lpht_pkg::ST_HASH;
      lpht_pkg::ST_HASH:  if (hash_res.done) state_nxt = lpht_pkg::ST_PROBE;
      lpht_pkg::ST_PROBE: if (stop) state_nxt = lpht_pkg::ST_DONE;
      lpht_pkg::ST_DONE:  if (out_free) state_nxt = lpht_pkg::ST_IDLE;
      default:            state_nxt = lpht_pkg::ST_CLEAR;
    endcase
  end

  // memory controls per state
  always_comb begin
    rd_en      = 1'b0;
    rd_addr    = cur_r;
    key_we     = 1'b0;
    mark_we    = 1'b0;
    wr_addr    = cur_r;
    mark_wdata = hit_mark;
    unique case (state_r)
      lpht_pkg::ST_CLEAR: begin
        mark_we    = 1'b1;
        wr_addr    = clr_r;
        mark_wdata = lpht_pkg::MARK_EMPTY;
      end
      lpht_pkg::ST_HASH: begin
        // fetch the home slot as soon as it is known
        rd_en   = hash_res.done;
        rd_addr = hash_res.home;
      end
      lpht_pkg::ST_PROBE: begin
        if (stop) begin
          mark_we = hit_write;
          key_we  = hit_key_write;
        end else begin
          // advance: fetch the next slot while this one is judged
          rd_en   = 1'b1;
          rd_addr = lpht_pkg::next_slot(cur_r);
        end
      end
      lpht_pkg::ST_IDLE, lpht_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpht_pkg::ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == lpht_pkg::ST_CLEAR) begin
        clr_r <= clr_r + lpht_pkg::SLOT_W'(1);
      end
      if (state_r == lpht_pkg::ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r <= in_func;
      key_r  <= in_key;
    end
    if (state_r == lpht_pkg::ST_HASH && hash_res.done) begin
      cur_r <= hash_res.home;
      cnt_r <= '0;
    end else if (state_r == lpht_pkg::ST_PROBE && !stop) begin
      cur_r <= lpht_pkg::next_slot(cur_r);
      cnt_r <= cnt_r + lpht_pkg::SLOT_W'(1);
    end
    if (state_r == lpht_pkg::ST_PROBE && stop) begin
      res_status_r <= stop_status;
      res_slot_r   <= stop_slot;
    end
    if (state_r == lpht_pkg::ST_DONE && out_free) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;

`ifndef SYNTHESIS
  // a write-back never shares a cycle with a probe fetch
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !((key_we || mark_we) && rd_en))
    else $error("memory write coincides with a probe read");

  // the home slot arrives only while the sequencer waits for it
  a_hash_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    hash_res.done |-> (state_r == lpht_pkg::ST_HASH))
    else $error("home slot ready outside the hash state");

  // an accepted request is hashed in the following cycle
  a_accept_hash: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == lpht_pkg::ST_HASH))
    else $error("accepted request did not move to hashing");

  // a delivered result carries a defined status code
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_status_r <= lpht_pkg::ST_DELETED))
    else $error("result with undefined status");
`endif

endmodule
